// ===== design/xss_pkg.sv =====
// ----------------------------------------------------------------------------
// XSalsa20 stream unit package
// Shared types, codes, constants and helper functions for the stream unit.
// ----------------------------------------------------------------------------
package xss_pkg;

  // Input kind codes as they arrive on the input channel.
  localparam logic [1:0] KIND_START  = 2'd0;
  localparam logic [1:0] KIND_DATA   = 2'd1;
  localparam logic [1:0] KIND_WIPE   = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] CFG_KEY_WORD0   = 3'd0;
  localparam logic [2:0] CFG_KEY_WORD1   = 3'd1;
  localparam logic [2:0] CFG_KEY_WORD2   = 3'd2;
  localparam logic [2:0] CFG_KEY_WORD3   = 3'd3;
  localparam logic [2:0] CFG_NONCE_WORD0 = 3'd4;
  localparam logic [2:0] CFG_NONCE_WORD1 = 3'd5;
  localparam logic [2:0] CFG_NONCE_WORD2 = 3'd6;

  // Sizes.
  localparam int QueueDepth = 4;
  localparam int QueuePtrW  = $clog2(QueueDepth);
  localparam int Rounds     = 20;
  localparam int RoundW     = $clog2(Rounds);
  localparam logic [RoundW-1:0] LAST_ROUND = RoundW'(Rounds - 1);
  localparam logic [6:0] BLOCK_BYTES = 7'd64;

  // Salsa20 constant words ("expand 32-byte k").
  localparam logic [31:0] SIGMA0 = 32'h6170_7865;
  localparam logic [31:0] SIGMA1 = 32'h3320_646e;
  localparam logic [31:0] SIGMA2 = 32'h7962_2d32;
  localparam logic [31:0] SIGMA3 = 32'h6b20_6574;

  // Operations after classification in the front part.
  typedef enum logic [1:0] {
    OP_START,
    OP_DATA,
    OP_WIPE,
    OP_NONE
  } op_t;

  // Back part sequencer states.
  typedef enum logic [1:0] {
    BK_RUN,
    BK_HSALSA,
    BK_REPLY,
    BK_BLOCK
  } back_state_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_in;
  } in_payload_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       status;
  } out_payload_t;

  // Head of the command queue as seen by the back part.
  typedef struct packed {
    logic       valid;
    op_t        op;
    logic [7:0] data;
  } q_head_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [2:0][63:0] nonce;
    logic [3:0][63:0] key;
  } cfg_regs_t;

  typedef logic [15:0][31:0] salsa_state_t;

  // Word index of a quarter-round role; row selects the row round.
  function automatic logic [3:0] quarter_index(logic row, logic [1:0] q, logic [1:0] role);
    logic [3:0] col_tab [4][4];
    logic [3:0] row_tab [4][4];
    col_tab = '{'{4'd0, 4'd4, 4'd8, 4'd12}, '{4'd5, 4'd9, 4'd13, 4'd1},
                '{4'd10, 4'd14, 4'd2, 4'd6}, '{4'd15, 4'd3, 4'd7, 4'd11}};
    row_tab = '{'{4'd0, 4'd1, 4'd2, 4'd3}, '{4'd5, 4'd6, 4'd7, 4'd4},
                '{4'd10, 4'd11, 4'd8, 4'd9}, '{4'd15, 4'd12, 4'd13, 4'd14}};
    return row ? row_tab[q][role] : col_tab[q][role];
  endfunction

  // Rotate left by the amount used in the given quarter-round step.
  function automatic logic [31:0] step_rotate(logic [31:0] v, logic [1:0] step);
    logic [31:0] r;
    unique case (step)
      2'd0: r = {v[24:0], v[31:25]};
      2'd1: r = {v[22:0], v[31:23]};
      2'd2: r = {v[18:0], v[31:19]};
      default: r = {v[13:0], v[31:14]};
    endcase
    return r;
  endfunction

  // Initial Salsa20 matrix from eight key words and four variable words.
  function automatic salsa_state_t build_state(logic [7:0][31:0] w, logic [3:0][31:0] v);
    salsa_state_t s;
    s[0]  = SIGMA0; s[5] = SIGMA1; s[10] = SIGMA2; s[15] = SIGMA3;
    s[1]  = w[0];   s[2] = w[1];   s[3]  = w[2];   s[4]  = w[3];
    s[11] = w[4];   s[12] = w[5];  s[13] = w[6];   s[14] = w[7];
    s[6]  = v[0];   s[7] = v[1];   s[8]  = v[2];   s[9]  = v[3];
    return s;
  endfunction

endpackage

// ===== design/xss_stream_if.sv =====
// ----------------------------------------------------------------------------
// Stream channel interface
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface xss_stream_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/xss_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write interface
// Valid/ready write channel with register index and write data.
// ----------------------------------------------------------------------------
interface xss_cfg_if ();
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== design/xss_front.sv =====
// ----------------------------------------------------------------------------
// Stream unit front end
// Holds the configuration registers, classifies input beats and queues them.
// ----------------------------------------------------------------------------
module xss_front (
  input  logic             clk,
  input  logic             rst,
  xss_stream_if.sink       in_item,
  xss_cfg_if.sink          cfg,
  input  logic             pop,
  output xss_pkg::q_head_t head,
  output xss_pkg::cfg_regs_t cfg_regs
);

  xss_pkg::op_t             q_op   [xss_pkg::QueueDepth];
  logic [7:0]               q_data [xss_pkg::QueueDepth];
  logic [xss_pkg::QueuePtrW-1:0] wr_ptr;
  logic [xss_pkg::QueuePtrW-1:0] rd_ptr;
  logic [xss_pkg::QueuePtrW:0]   count;
  logic                     push;
  logic                     do_pop;
  xss_pkg::op_t             op_in;

  // Configuration writes are always taken.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs <= '0;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        xss_pkg::CFG_KEY_WORD0:   cfg_regs.key[0]   <= cfg.data;
        xss_pkg::CFG_KEY_WORD1:   cfg_regs.key[1]   <= cfg.data;
        xss_pkg::CFG_KEY_WORD2:   cfg_regs.key[2]   <= cfg.data;
        xss_pkg::CFG_KEY_WORD3:   cfg_regs.key[3]   <= cfg.data;
        xss_pkg::CFG_NONCE_WORD0: cfg_regs.nonce[0] <= cfg.data;
        xss_pkg::CFG_NONCE_WORD1: cfg_regs.nonce[1] <= cfg.data;
        xss_pkg::CFG_NONCE_WORD2: cfg_regs.nonce[2] <= cfg.data;
        default: ;
      endcase
    end
  end

  // Classify the input kind into an operation.
  always_comb begin
    unique case (in_item.payload.kind)
      xss_pkg::KIND_START: op_in = xss_pkg::OP_START;
      xss_pkg::KIND_DATA:  op_in = xss_pkg::OP_DATA;
      xss_pkg::KIND_WIPE:  op_in = xss_pkg::OP_WIPE;
      default:             op_in = xss_pkg::OP_NONE;
    endcase
  end

  // Queue handshake.
  assign in_item.ready = (count != (xss_pkg::QueuePtrW+1)'(xss_pkg::QueueDepth));
  assign push          = in_item.valid && in_item.ready;
  assign do_pop        = pop && (count != '0);

  assign head.valid = (count != '0);
  assign head.op    = q_op[rd_ptr];
  assign head.data  = q_data[rd_ptr];

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]   <= op_in;
      q_data[wr_ptr] <= in_item.payload.data_in;
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !do_pop) count <= count + 1'b1;
      else if (!push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

// ===== design/xss_core.sv =====
// ----------------------------------------------------------------------------
// Salsa20 round core
// Iterative permutation: one quarter-round step of four parallel quarters
// per cycle, repeated over 20 rounds.
// ----------------------------------------------------------------------------
module xss_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  xss_pkg::salsa_state_t init,
  output logic                  done,
  output xss_pkg::salsa_state_t z,
  output xss_pkg::salsa_state_t x
);

  logic [1:0]                 step;
  logic [xss_pkg::RoundW-1:0] rnd;
  logic                       busy;
  xss_pkg::salsa_state_t      z_next;

  // One step of the four independent quarter rounds.
  always_comb begin
    logic [3:0]  tgt;
    logic [3:0]  src1;
    logic [3:0]  src2;
    z_next = z;
    for (int q = 0; q < 4; q++) begin
      tgt  = xss_pkg::quarter_index(rnd[0], 2'(q), step + 2'd1);
      src1 = xss_pkg::quarter_index(rnd[0], 2'(q), step);
      src2 = xss_pkg::quarter_index(rnd[0], 2'(q), step + 2'd3);
      z_next[tgt] = z[tgt] ^ xss_pkg::step_rotate(z[src1] + z[src2], step);
    end
  end

  // Round sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
      rnd  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        z    <= init;
        x    <= init;
        step <= '0;
        rnd  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        z    <= z_next;
        step <= step + 2'd1;
        if (step == 2'd3) begin
          rnd <= rnd + 1'b1;
          if (rnd == xss_pkg::LAST_ROUND) begin
            busy <= 1'b0;
            done <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// ===== design/xss_back.sv =====
// ----------------------------------------------------------------------------
// Stream unit back end
// Executes queued operations: session start, keystream XOR, wipe. Owns the
// session state, keystream buffer and the output register.
// ----------------------------------------------------------------------------
module xss_back (
  input  logic               clk,
  input  logic               rst,
  input  xss_pkg::q_head_t   head,
  output logic               pop,
  input  xss_pkg::cfg_regs_t cfg_regs,
  xss_stream_if.source       out_item
);

  xss_pkg::back_state_t   state;
  xss_pkg::back_state_t   state_next;
  logic [7:0][31:0]       subkey;
  logic [63:0]            nonce_hi;
  logic [63:0]            block_count;
  logic [15:0][3:0][7:0]  keystream;
  logic [6:0]             byte_position;
  logic                   session_active;
  logic                   out_valid;
  xss_pkg::out_payload_t  out_data;

  logic                   out_free;
  logic                   emit;
  xss_pkg::out_payload_t  emit_data;
  logic                   advance;
  logic                   wipe;
  logic                   core_start;
  logic                   core_done;
  xss_pkg::salsa_state_t  core_init;
  xss_pkg::salsa_state_t  core_z;
  xss_pkg::salsa_state_t  core_x;
  logic [7:0]             ks_byte;

  assign out_free = !out_valid || out_item.ready;
  assign ks_byte  = keystream[byte_position[5:2]][byte_position[1:0]];

  xss_core u_core (
    .clk   (clk),
    .rst   (rst),
    .start (core_start),
    .init  (core_init),
    .done  (core_done),
    .z     (core_z),
    .x     (core_x)
  );

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      xss_pkg::BK_RUN: begin
        if (head.valid && out_free) begin
          if (head.op == xss_pkg::OP_START) state_next = xss_pkg::BK_HSALSA;
          else if (head.op == xss_pkg::OP_DATA && session_active && byte_position[6])
            state_next = xss_pkg::BK_BLOCK;
        end
      end
      xss_pkg::BK_HSALSA: if (core_done) state_next = xss_pkg::BK_REPLY;
      xss_pkg::BK_REPLY:  if (out_free) state_next = xss_pkg::BK_RUN;
      xss_pkg::BK_BLOCK:  if (core_done) state_next = xss_pkg::BK_RUN;
      default:            state_next = xss_pkg::BK_RUN;
    endcase
  end

  // Control outputs.
  always_comb begin
    emit       = 1'b0;
    emit_data  = '0;
    pop        = 1'b0;
    advance    = 1'b0;
    wipe       = 1'b0;
    core_start = 1'b0;
    if (head.op == xss_pkg::OP_START)
      core_init = xss_pkg::build_state(cfg_regs.key, cfg_regs.nonce[1:0]);
    else
      core_init = xss_pkg::build_state(subkey, {block_count, nonce_hi});
    unique case (state)
      xss_pkg::BK_RUN: begin
        if (head.valid && out_free) begin
          unique case (head.op)
            xss_pkg::OP_START: core_start = 1'b1;
            xss_pkg::OP_DATA: begin
              if (!session_active) begin
                emit             = 1'b1;
                pop              = 1'b1;
                emit_data.status = 1'b1;
              end else if (byte_position[6]) begin
                core_start = 1'b1;
              end else begin
                emit               = 1'b1;
                pop                = 1'b1;
                advance            = 1'b1;
                emit_data.data_out = head.data ^ ks_byte;
              end
            end
            xss_pkg::OP_WIPE: begin
              emit = 1'b1;
              pop  = 1'b1;
              wipe = 1'b1;
            end
            default: begin
              emit = 1'b1;
              pop  = 1'b1;
            end
          endcase
        end
      end
      xss_pkg::BK_REPLY: begin
        if (out_free) begin
          emit = 1'b1;
          pop  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Session state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= xss_pkg::BK_RUN;
      subkey         <= '0;
      nonce_hi       <= '0;
      block_count    <= '0;
      byte_position  <= xss_pkg::BLOCK_BYTES;
      session_active <= 1'b0;
    end else begin
      state <= state_next;
      if (state == xss_pkg::BK_HSALSA && core_done) begin
        subkey[0] <= core_z[0];  subkey[1] <= core_z[5];
        subkey[2] <= core_z[10]; subkey[3] <= core_z[15];
        subkey[4] <= core_z[6];  subkey[5] <= core_z[7];
        subkey[6] <= core_z[8];  subkey[7] <= core_z[9];
        nonce_hi       <= cfg_regs.nonce[2];
        block_count    <= '0;
        byte_position  <= xss_pkg::BLOCK_BYTES;
        session_active <= 1'b1;
      end else if (state == xss_pkg::BK_BLOCK && core_done) begin
        block_count   <= block_count + 64'd1;
        byte_position <= '0;
      end else if (advance) begin
        byte_position <= byte_position + 7'd1;
      end else if (wipe) begin
        subkey         <= '0;
        nonce_hi       <= '0;
        block_count    <= '0;
        byte_position  <= '0;
        session_active <= 1'b0;
      end
    end
  end

  // Keystream buffer, loaded with the feed-forward sum of a finished block.
  always_ff @(posedge clk) begin
    if (state == xss_pkg::BK_BLOCK && core_done) begin
      for (int i = 0; i < 16; i++) keystream[i] <= core_z[i] + core_x[i];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_item.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data <= emit_data;
  end

  assign out_item.valid   = out_valid;
  assign out_item.payload = out_data;

endmodule

// ===== design/xsalsa20_stream_xor_unit.sv =====
// ----------------------------------------------------------------------------
// XSalsa20 stream XOR unit
// Byte-wide XSalsa20 encryptor/decryptor with a queued front end.
// ----------------------------------------------------------------------------
// Usage: write key and nonce words on cfg while the unit is idle, then send
// a start beat on in_item, followed by data beats; each input beat gives
// exactly one output beat on out_item, in order.
// A start beat runs HSalsa20 on the shared round core; its result beat
// leaves through BK_REPLY and the output register once the rounds finish.
// A data beat whose keystream byte is buffered passes the queue and the
// output register; one byte per cycle is sustained while out_item.ready is
// high. The first data byte of a session and every 64th after it wait for a
// new Salsa20 block; the round core does one quarter-round step per cycle.
// A four-entry queue separates the input and output sides, so input beats
// are taken while results wait; when the receiver stalls the output register
// holds and the queue fills, then in_item.ready drops.
// Reset clears the configuration, the session and the queue; the unit is
// inactive until the next start beat.
// ----------------------------------------------------------------------------
module xsalsa20_stream_xor_unit (
  input  logic         clk,
  input  logic         rst,
  xss_stream_if.sink   in_item,
  xss_stream_if.source out_item,
  xss_cfg_if.sink      cfg
);

  xss_pkg::q_head_t   head;
  xss_pkg::cfg_regs_t cfg_regs;
  logic               pop;

  xss_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .cfg      (cfg),
    .pop      (pop),
    .head     (head),
    .cfg_regs (cfg_regs)
  );

  xss_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .pop      (pop),
    .cfg_regs (cfg_regs),
    .out_item (out_item)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// XSalsa20 stream unit testbench
// Drives start, data and wipe beats with random gaps and output stalls,
// predicts every result with an in-bench Salsa20 model and checks in order.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int WatchdogLimit = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #1 clk = ~clk;

  xss_stream_if #(.payload_t(xss_pkg::in_payload_t))  in_item ();
  xss_stream_if #(.payload_t(xss_pkg::out_payload_t)) out_item ();
  xss_cfg_if cfg ();

  xsalsa20_stream_xor_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_item  (in_item),
    .out_item (out_item),
    .cfg      (cfg)
  );

  // Predictor copy of registers and session state.
  logic [63:0] cfg_copy [7];
  logic [31:0] subkey [8];
  logic [63:0] nonce_hi;
  logic [63:0] block_count;
  logic [7:0]  key_bytes [64];
  logic [6:0]  byte_pos;
  logic        active;

  xss_pkg::out_payload_t expected_q [$];
  int error_count = 0;
  int beats_out = 0;
  int data_beats = 0;
  int blocks_made = 0;
  int idle_cycles = 0;
  bit in_idle_on = 1'b1;
  bit out_idle_on = 1'b1;

  function automatic logic [31:0] rotl(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  // Twenty Salsa20 rounds in place.
  function automatic void salsa_rounds(ref logic [31:0] z [16]);
    int qi [8][4];
    qi = '{'{0, 4, 8, 12}, '{5, 9, 13, 1}, '{10, 14, 2, 6}, '{15, 3, 7, 11},
           '{0, 1, 2, 3}, '{5, 6, 7, 4}, '{10, 11, 8, 9}, '{15, 12, 13, 14}};
    for (int r = 0; r < 10; r++) begin
      for (int q = 0; q < 8; q++) begin
        z[qi[q][1]] ^= rotl(z[qi[q][0]] + z[qi[q][3]], 7);
        z[qi[q][2]] ^= rotl(z[qi[q][1]] + z[qi[q][0]], 9);
        z[qi[q][3]] ^= rotl(z[qi[q][2]] + z[qi[q][1]], 13);
        z[qi[q][0]] ^= rotl(z[qi[q][3]] + z[qi[q][2]], 18);
      end
    end
  endfunction

  function automatic void load_matrix(ref logic [31:0] s [16], input logic [31:0] w [8],
                                      input logic [31:0] v [4]);
    s[0] = xss_pkg::SIGMA0; s[5] = xss_pkg::SIGMA1;
    s[10] = xss_pkg::SIGMA2; s[15] = xss_pkg::SIGMA3;
    s[1] = w[0]; s[2] = w[1]; s[3] = w[2]; s[4] = w[3];
    s[11] = w[4]; s[12] = w[5]; s[13] = w[6]; s[14] = w[7];
    s[6] = v[0]; s[7] = v[1]; s[8] = v[2]; s[9] = v[3];
  endfunction

  function automatic void clear_session();
    for (int i = 0; i < 8; i++) subkey[i] = '0;
    for (int i = 0; i < 64; i++) key_bytes[i] = '0;
    nonce_hi = '0;
    block_count = '0;
    byte_pos = '0;
    active = 1'b0;
  endfunction

  // Expected result of one input beat; updates the session copy.
  function automatic xss_pkg::out_payload_t predict_cipher(xss_pkg::in_payload_t it);
    xss_pkg::out_payload_t res;
    logic [31:0] w [8];
    logic [31:0] v [4];
    logic [31:0] x [16];
    logic [31:0] z [16];
    res = '0;
    if (it.kind == xss_pkg::KIND_START) begin
      for (int i = 0; i < 4; i++) begin
        w[2*i] = cfg_copy[i][31:0];
        w[2*i+1] = cfg_copy[i][63:32];
      end
      v = '{cfg_copy[4][31:0], cfg_copy[4][63:32], cfg_copy[5][31:0], cfg_copy[5][63:32]};
      load_matrix(z, w, v);
      salsa_rounds(z);
      subkey = '{z[0], z[5], z[10], z[15], z[6], z[7], z[8], z[9]};
      nonce_hi = cfg_copy[6];
      block_count = '0;
      for (int i = 0; i < 64; i++) key_bytes[i] = '0;
      byte_pos = xss_pkg::BLOCK_BYTES;
      active = 1'b1;
    end else if (it.kind == xss_pkg::KIND_DATA) begin
      if (!active) begin
        res.status = 1'b1;
      end else begin
        if (byte_pos >= xss_pkg::BLOCK_BYTES) begin
          v = '{nonce_hi[31:0], nonce_hi[63:32], block_count[31:0], block_count[63:32]};
          load_matrix(x, subkey, v);
          z = x;
          salsa_rounds(z);
          for (int i = 0; i < 16; i++) begin
            logic [31:0] s;
            s = z[i] + x[i];
            for (int b = 0; b < 4; b++) key_bytes[4*i+b] = s[8*b +: 8];
          end
          block_count++;
          byte_pos = '0;
          blocks_made++;
        end
        res.data_out = it.data_in ^ key_bytes[byte_pos[5:0]];
        byte_pos++;
        data_beats++;
      end
    end else if (it.kind == xss_pkg::KIND_WIPE) begin
      clear_session();
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0h, want %0h (result %0d)", what, got, want, beats_out);
    error_count++;
  endtask

  // Output side: random stalls and in-order checking.
  always @(posedge clk) begin
    if (rst) begin
      out_item.ready <= 1'b0;
    end else begin
      out_item.ready <= !out_idle_on || ($urandom_range(99) >= 20);
      if (out_item.valid && out_item.ready) begin
        xss_pkg::out_payload_t want;
        beats_out++;
        if (expected_q.size() == 0) begin
          report_mismatch("unexpected result beat", int'(out_item.payload), 0);
        end else begin
          want = expected_q.pop_front();
          if (out_item.payload.data_out !== want.data_out)
            report_mismatch("data_out", int'(out_item.payload.data_out),
                            int'(want.data_out));
          if (out_item.payload.status !== want.status)
            report_mismatch("status", int'(out_item.payload.status), int'(want.status));
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk) begin
    if ((in_item.valid && in_item.ready) || (out_item.valid && out_item.ready)
        || (cfg.valid && cfg.ready)) begin
      idle_cycles <= 0;
    end else if (!rst && (idle_cycles + 1 >= WatchdogLimit)) begin
      $display("Watchdog expired with %0d results pending", expected_q.size());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Valid stays high after a beat; the next beat, an idle gap or a drain
  // takes it over in the same time step.
  task automatic send_item(logic [1:0] kind, logic [7:0] data);
    xss_pkg::in_payload_t it;
    it.kind = kind;
    it.data_in = data;
    while (in_idle_on && $urandom_range(99) < 20) begin
      in_item.valid <= 1'b0;
      @(posedge clk);
    end
    in_item.valid <= 1'b1;
    in_item.payload <= it;
    do @(posedge clk); while (!in_item.ready);
    expected_q.push_back(predict_cipher(it));
  endtask

  // Checked-item variant: result typed in by hand.
  task automatic send_known(logic [1:0] kind, logic [7:0] data, xss_pkg::out_payload_t want);
    xss_pkg::out_payload_t got;
    send_item(kind, data);
    got = expected_q[$];
    if (got !== want) report_mismatch("predictor vs table", int'(got), int'(want));
  endtask

  task automatic drain();
    in_item.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= val;
    do @(posedge clk); while (!cfg.ready);
    cfg_copy[idx] = val;
  endtask

  task automatic write_all(logic [63:0] v0, logic [63:0] v1, bit rnd);
    write_reg(xss_pkg::CFG_KEY_WORD0, rnd ? {$urandom, $urandom} : v0);
    write_reg(xss_pkg::CFG_KEY_WORD1, rnd ? {$urandom, $urandom} : v1);
    write_reg(xss_pkg::CFG_KEY_WORD2, rnd ? {$urandom, $urandom} : v0);
    write_reg(xss_pkg::CFG_KEY_WORD3, rnd ? {$urandom, $urandom} : v1);
    write_reg(xss_pkg::CFG_NONCE_WORD0, rnd ? {$urandom, $urandom} : v0);
    write_reg(xss_pkg::CFG_NONCE_WORD1, rnd ? {$urandom, $urandom} : v1);
    write_reg(xss_pkg::CFG_NONCE_WORD2, rnd ? {$urandom, $urandom} : v0);
    cfg.valid <= 1'b0;
  endtask

  typedef struct {
    logic [1:0]            kind;
    logic [7:0]            data;
    bit                    known;
    xss_pkg::out_payload_t want;
  } stim_row_t;

  stim_row_t directed [] = '{
    '{xss_pkg::KIND_DATA,   8'hff, 1, '{8'h00, 1'b1}},   // data before any session
    '{xss_pkg::KIND_WIPE,   8'h00, 1, '{8'h00, 1'b0}},
    '{xss_pkg::KIND_UNUSED, 8'hff, 1, '{8'h00, 1'b0}},   // unused kind is ignored
    '{xss_pkg::KIND_DATA,   8'h00, 1, '{8'h00, 1'b1}},
    '{xss_pkg::KIND_START,  8'hff, 1, '{8'h00, 1'b0}},
    '{xss_pkg::KIND_DATA,   8'h00, 0, '{8'h00, 1'b0}},
    '{xss_pkg::KIND_DATA,   8'hff, 0, '{8'h00, 1'b0}},
    '{xss_pkg::KIND_DATA,   8'h5a, 0, '{8'h00, 1'b0}},
    '{xss_pkg::KIND_START,  8'h00, 1, '{8'h00, 1'b0}},   // restart while active
    '{xss_pkg::KIND_DATA,   8'ha5, 0, '{8'h00, 1'b0}},
    '{xss_pkg::KIND_UNUSED, 8'h00, 1, '{8'h00, 1'b0}},
    '{xss_pkg::KIND_DATA,   8'h01, 0, '{8'h00, 1'b0}},
    '{xss_pkg::KIND_WIPE,   8'hff, 1, '{8'h00, 1'b0}},
    '{xss_pkg::KIND_DATA,   8'h80, 1, '{8'h00, 1'b1}}    // inactive after wipe
  };

  // A start beat followed by a run of data, sometimes crossing blocks.
  task automatic session_burst(int len);
    send_item(xss_pkg::KIND_START, 8'($urandom));
    for (int i = 0; i < len; i++) send_item(xss_pkg::KIND_DATA, 8'($urandom));
  endtask

  initial begin
    int sent;
    in_item.valid = 1'b0;
    in_item.payload = '0;
    cfg.valid = 1'b0;
    cfg.index = xss_pkg::CFG_KEY_WORD0;
    cfg.data = '0;
    for (int i = 0; i < 7; i++) cfg_copy[i] = '0;
    clear_session();
    byte_pos = xss_pkg::BLOCK_BYTES;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table with all-zero registers, then all-ones.
    foreach (directed[i]) begin
      if (directed[i].known) send_known(directed[i].kind, directed[i].data, directed[i].want);
      else send_item(directed[i].kind, directed[i].data);
    end
    drain();
    write_all('1, '1, 0);
    foreach (directed[i]) send_item(directed[i].kind, directed[i].data);
    drain();

    // Random phases: new keys each time, one with no idling at all.
    sent = 0;
    for (int ph = 0; sent < 600; ph++) begin
      write_all(ph[0] ? 64'h0 : '1, 64'h8000_0000_0000_0001, ph > 1);
      in_idle_on = (ph != 1);
      out_idle_on = (ph != 1);
      for (int b = 0; b < 4; b++) begin
        int r;
        int len;
        r = $urandom_range(9);
        len = (r < 2) ? $urandom_range(65, 140) : $urandom_range(1, 40);
        session_burst(len);
        sent += len + 1;
        if ($urandom_range(9) < 2) begin
          send_item(2'($urandom_range(3)), 8'($urandom));
          sent++;
        end
      end
      drain();
    end

    $display("Covered %0d result beats, %0d keystream bytes, %0d keystream blocks.",
             beats_out, data_beats, blocks_made);
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Errors: %0d", error_count);
      $display("Verification failed");
    end
    $finish;
  end
endmodule
